[hw/rtl/assert_macros.svh]
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define APF_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("apf same-cycle check failed");
`define APF_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("apf next-cycle check failed");
`else
`define APF_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define APF_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

[hw/rtl/apf_pkg.sv]
// types and constants of the articulation point finder
package apf_pkg;
	localparam int MAX_VERTICES = 64;
	localparam int VW = $clog2(MAX_VERTICES);
	localparam int CW = VW + 1;
	localparam logic [CW-1:0] VCOUNT_RESET = CW'(MAX_VERTICES);

	typedef struct packed {
		logic [VW-1:0] end_a;
		logic [VW-1:0] end_b;
		logic          final_edge;
	} in_item_t;

	typedef struct packed {
		logic [VW-1:0] vertex_index;
		logic          is_cut;
		logic          last_result;
	} out_item_t;

	typedef struct packed {
		logic [VW-1:0] disc;
		logic [VW-1:0] low;
		logic [CW-1:0] pos;
		logic [VW-1:0] parent;
	} vtx_entry_t;

	localparam int VTX_W = $bits(vtx_entry_t);
endpackage

[hw/rtl/apf_ram.sv]
// simple dual-port synchronous ram with registered read
module apf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

[hw/rtl/apf_ctrl.sv]
// edge loading, depth-first search sequencer and result output
module apf_ctrl (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic [apf_pkg::CW-1:0]                 n_eff,
	input  logic                                   in_valid,
	output logic                                   in_stall,
	input  apf_pkg::in_item_t                      in_data,
	output logic                                   out_valid,
	input  logic                                   out_stall,
	output apf_pkg::out_item_t                     out_data,
	output logic                                   adj_we,
	output logic [apf_pkg::VW-1:0]                 adj_waddr,
	output logic [apf_pkg::MAX_VERTICES-1:0]       adj_wdata,
	output logic [apf_pkg::VW-1:0]                 adj_raddr,
	input  logic [apf_pkg::MAX_VERTICES-1:0]       adj_rdata,
	output logic                                   vtx_we,
	output logic [apf_pkg::VW-1:0]                 vtx_waddr,
	output apf_pkg::vtx_entry_t                    vtx_wdata,
	output logic [apf_pkg::VW-1:0]                 vtx_raddr,
	input  apf_pkg::vtx_entry_t                    vtx_rdata
);
	typedef enum logic [2:0] {
		ST_IDLE, ST_WA, ST_WB, ST_NEXT, ST_ROW, ST_SCAN, ST_BACK, ST_POP
	} state_t;
	localparam int NV = apf_pkg::MAX_VERTICES;
	localparam int VW = apf_pkg::VW;
	localparam int CW = apf_pkg::CW;
	localparam logic [1:0] RCNT_MAX = 2'd2;

	state_t             state_q;
	logic               out_phase_q;
	logic [VW-1:0]      a_q, b_q;
	logic               fin_q;
	logic [NV-1:0]      row_vld_q, visited_q, cut_q;
	logic [NV-1:0]      row_q;
	logic [CW-1:0]      clk_cnt_q, r_q, pos_q, idx_q;
	logic [VW-1:0]      v_q, root_q, parent_q, disc_q, low_q;
	logic [1:0]         rcnt_q;
	logic               out_vld_q;
	apf_pkg::out_item_t out_q;

	logic               edge_ok;
	logic [VW-1:0]      w;
	logic               scan_end, bit_set, is_root, out_load;
	logic [NV-1:0]      cur_row;

	assign edge_ok = ({1'b0, in_data.end_a} < n_eff) && ({1'b0, in_data.end_b} < n_eff)
		&& (in_data.end_a != in_data.end_b);
	assign w        = pos_q[VW-1:0];
	assign scan_end = pos_q >= n_eff;
	assign bit_set  = row_q[w];
	assign is_root  = v_q == root_q;
	assign cur_row  = row_vld_q[a_q] ? adj_rdata : '0;
	assign out_load = out_phase_q && (!out_vld_q || !out_stall);

	assign in_stall  = (state_q != ST_IDLE) || out_phase_q;
	assign out_valid = out_vld_q;
	assign out_data  = out_q;

	always_comb begin
		adj_we    = 1'b0;
		adj_waddr = a_q;
		adj_wdata = cur_row | (NV'(1) << b_q);
		case (state_q)
			ST_WA: begin
				adj_we = 1'b1;
			end
			ST_WB: begin
				adj_we    = 1'b1;
				adj_waddr = b_q;
				adj_wdata = (row_vld_q[b_q] ? adj_rdata : '0) | (NV'(1) << a_q);
			end
			default: begin
				adj_we = 1'b0;
			end
		endcase
	end

	always_comb begin
		case (state_q)
			ST_IDLE: adj_raddr = in_data.end_a;
			ST_WA:   adj_raddr = b_q;
			ST_NEXT: adj_raddr = r_q[VW-1:0];
			ST_SCAN: adj_raddr = w;
			ST_POP:  adj_raddr = parent_q;
			default: adj_raddr = v_q;
		endcase
	end

	// entry saved on every push and again when the vertex finishes
	assign vtx_we           = (state_q == ST_SCAN) && (scan_end || (bit_set
		&& !(!is_root && w == parent_q) && !visited_q[w]));
	assign vtx_waddr        = v_q;
	assign vtx_wdata.disc   = disc_q;
	assign vtx_wdata.low    = low_q;
	assign vtx_wdata.pos    = pos_q + CW'(1);
	assign vtx_wdata.parent = parent_q;
	assign vtx_raddr        = (state_q == ST_SCAN && !scan_end) ? w : parent_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_phase_q <= 1'b0;
			row_vld_q   <= '0;
			visited_q   <= '0;
			cut_q       <= '0;
			clk_cnt_q   <= '0;
			rcnt_q      <= '0;
			out_vld_q   <= 1'b0;
			r_q         <= '0;
			idx_q       <= '0;
		end else begin
			if (out_load) begin
				out_vld_q          <= 1'b1;
				out_q.vertex_index <= idx_q[VW-1:0];
				out_q.is_cut       <= cut_q[idx_q[VW-1:0]];
				out_q.last_result  <= (idx_q + CW'(1)) == n_eff;
				idx_q              <= idx_q + CW'(1);
				if ((idx_q + CW'(1)) == n_eff) begin
					// store cleared as the last result is loaded
					out_phase_q <= 1'b0;
					row_vld_q   <= '0;
					visited_q   <= '0;
					cut_q       <= '0;
					clk_cnt_q   <= '0;
				end
			end else if (out_vld_q && !out_stall) begin
				out_vld_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_valid && !out_phase_q) begin
						a_q   <= in_data.end_a;
						b_q   <= in_data.end_b;
						fin_q <= in_data.final_edge;
						r_q   <= '0;
						if (edge_ok) begin
							state_q <= ST_WA;
						end else if (in_data.final_edge) begin
							state_q <= ST_NEXT;
						end
					end
				end
				ST_WA: begin
					row_vld_q[a_q] <= 1'b1;
					state_q        <= ST_WB;
				end
				ST_WB: begin
					row_vld_q[b_q] <= 1'b1;
					state_q        <= fin_q ? ST_NEXT : ST_IDLE;
				end
				ST_NEXT: begin
					if (r_q >= n_eff) begin
						idx_q       <= '0;
						out_phase_q <= 1'b1;
						state_q     <= ST_IDLE;
					end else if (visited_q[r_q[VW-1:0]]) begin
						r_q <= r_q + CW'(1);
					end else begin
						root_q                 <= r_q[VW-1:0];
						rcnt_q                 <= '0;
						visited_q[r_q[VW-1:0]] <= 1'b1;
						v_q                    <= r_q[VW-1:0];
						disc_q                 <= clk_cnt_q[VW-1:0];
						low_q                  <= clk_cnt_q[VW-1:0];
						clk_cnt_q              <= clk_cnt_q + CW'(1);
						pos_q                  <= '0;
						state_q                <= ST_ROW;
					end
				end
				ST_ROW: begin
					row_q   <= row_vld_q[v_q] ? adj_rdata : '0;
					state_q <= ST_SCAN;
				end
				ST_SCAN: begin
					if (scan_end) begin
						if (is_root) begin
							if (rcnt_q == RCNT_MAX) begin
								cut_q[root_q] <= 1'b1;
							end
							r_q     <= r_q + CW'(1);
							state_q <= ST_NEXT;
						end else begin
							state_q <= ST_POP;
						end
					end else if (!bit_set || (!is_root && w == parent_q)) begin
						pos_q <= pos_q + CW'(1);
					end else if (!visited_q[w]) begin
						if (is_root && rcnt_q != RCNT_MAX) begin
							rcnt_q <= rcnt_q + 2'd1;
						end
						visited_q[w] <= 1'b1;
						parent_q     <= v_q;
						v_q          <= w;
						disc_q       <= clk_cnt_q[VW-1:0];
						low_q        <= clk_cnt_q[VW-1:0];
						clk_cnt_q    <= clk_cnt_q + CW'(1);
						pos_q        <= '0;
						state_q      <= ST_ROW;
					end else begin
						pos_q   <= pos_q + CW'(1);
						state_q <= ST_BACK;
					end
				end
				ST_BACK: begin
					if (vtx_rdata.disc < low_q) begin
						low_q <= vtx_rdata.disc;
					end
					state_q <= ST_SCAN;
				end
				ST_POP: begin
					if (parent_q != root_q && low_q >= vtx_rdata.disc) begin
						cut_q[parent_q] <= 1'b1;
					end
					low_q    <= (low_q < vtx_rdata.low) ? low_q : vtx_rdata.low;
					v_q      <= parent_q;
					disc_q   <= vtx_rdata.disc;
					pos_q    <= vtx_rdata.pos;
					parent_q <= vtx_rdata.parent;
					state_q  <= ST_ROW;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end
endmodule

[hw/rtl/articulation_point_finder_top.sv]
// top level of the articulation point finder
//
// channel  | handshake            | payload
// ---------+----------------------+-----------------------------
// in       | in_valid / in_stall  | in_data  (apf_pkg::in_item_t)
// out      | out_valid / out_stall| out_data (apf_pkg::out_item_t)
// config   | cfg_wr_en            | cfg_wr_data (vertex count)
//
// a stored edge uses ST_WA and ST_WB (two row read-modify-writes in the adjacency ram)
// the final edge then runs the search: the row scan tests one matrix bit per cycle
// while in ST_SCAN; a push, pop or back edge holds it in ST_ROW, ST_POP or ST_BACK
// results follow one per cycle while out_stall is low, the store clears with the last
// reset is asynchronous; no clearing pass, the rows carry valid flags
`include "assert_macros.svh"
module articulation_point_finder_top (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_wr_en,
	input  logic [apf_pkg::CW-1:0]          cfg_wr_data,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  apf_pkg::in_item_t               in_data,
	output logic                            out_valid,
	input  logic                            out_stall,
	output apf_pkg::out_item_t              out_data
);
	localparam int NV = apf_pkg::MAX_VERTICES;
	localparam int VW = apf_pkg::VW;
	localparam int CW = apf_pkg::CW;

	logic [CW-1:0]       vcount_q, n_eff, out_idx;
	logic                adj_we, vtx_we;
	logic [VW-1:0]       adj_waddr, adj_raddr, vtx_waddr, vtx_raddr;
	logic [NV-1:0]       adj_wdata, adj_rdata;
	apf_pkg::vtx_entry_t vtx_wdata, vtx_rdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vcount_q <= apf_pkg::VCOUNT_RESET;
		end else if (cfg_wr_en) begin
			vcount_q <= cfg_wr_data;
		end
	end

	always_comb begin
		if (vcount_q == '0) begin
			n_eff = CW'(1);
		end else if (vcount_q > CW'(NV)) begin
			n_eff = CW'(NV);
		end else begin
			n_eff = vcount_q;
		end
	end

	assign out_idx = {1'b0, out_data.vertex_index};

	apf_ram #(.WIDTH(NV), .DEPTH(NV)) u_adj_ram (
		.clk   (clk),
		.we    (adj_we),
		.waddr (adj_waddr),
		.wdata (adj_wdata),
		.raddr (adj_raddr),
		.rdata (adj_rdata)
	);

	apf_ram #(.WIDTH(apf_pkg::VTX_W), .DEPTH(NV)) u_vtx_ram (
		.clk   (clk),
		.we    (vtx_we),
		.waddr (vtx_waddr),
		.wdata (vtx_wdata),
		.raddr (vtx_raddr),
		.rdata (vtx_rdata)
	);

	apf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.n_eff     (n_eff),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.adj_we    (adj_we),
		.adj_waddr (adj_waddr),
		.adj_wdata (adj_wdata),
		.adj_raddr (adj_raddr),
		.adj_rdata (adj_rdata),
		.vtx_we    (vtx_we),
		.vtx_waddr (vtx_waddr),
		.vtx_wdata (vtx_wdata),
		.vtx_raddr (vtx_raddr),
		.vtx_rdata (vtx_rdata)
	);

	`APF_ASSERT_IMP(a_idx_range, clk, arst_n, out_valid, out_idx < n_eff)
	`APF_ASSERT_IMP(a_last_match, clk, arst_n, out_valid && out_data.last_result, (out_idx + CW'(1)) == n_eff)
	`APF_ASSERT_NXT(a_burst, clk, arst_n, out_valid && !out_stall && !out_data.last_result, out_valid)
	`APF_ASSERT_NXT(a_edge_busy, clk, arst_n, in_valid && !in_stall && in_data.final_edge, in_stall)
endmodule
